// File: rtl/sct_pkg.sv
// ----------------------------------------------------------------------------
// sct_pkg
// Shared types and constants of the sorted cell table: field widths, request
// and status codes, sequencer states and the cell control and flag bundles.
// ----------------------------------------------------------------------------
package sct_pkg;

  localparam int DEPTH_DEF     = 256;
  localparam int KEY_HALF_DEF  = 16;
  localparam int KEY_PORT_W    = 16;
  localparam int KEY_EXT_W     = 32;
  localparam int VALUE_W       = 32;

  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_INSERT = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_DUP  = 2'd1,
    STATUS_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic cmp_en;
    logic shift_en;
  } cell_ctrl_t;

  typedef struct packed {
    logic less;
    logic eq;
  } cell_flags_t;

endpackage

// File: rtl/sorted_cell_table.sv
// ----------------------------------------------------------------------------
// sorted_cell_table
// Table of up to DEPTH (row, column) keys with value handles, kept in
// ascending order in a chain of cells. Serves lookups and inserts.
// ----------------------------------------------------------------------------
//
//   channel   ports                                       handshake
//   request   in_req_type in_key_row in_key_col in_value_in  start / busy
//   result    out_found out_status out_position               out_valid
//             out_value_out out_entry_count
//
// Sequence: a request is taken into the request registers, compared by
// every cell in the compare state and committed (shift and write on insert)
// at the commit edge that ends the commit state; the result shows on the
// out_ ports for one cycle after that commit edge. busy is high only in the
// compare cycle, so a new request cannot be taken while the cells compare,
// but it can be taken at the commit edge of the request before it.
// Reset: rst_n (synchronous, active low) empties the table and the
// sequencer; cell contents are not cleared, the entry count masks them.
// The receiver cannot stall: each result is taken as it appears.
// ----------------------------------------------------------------------------
module sorted_cell_table import sct_pkg::*; #(
  parameter int DEPTH         = DEPTH_DEF,
  parameter int KEY_HALF_BITS = KEY_HALF_DEF,
  parameter int POS_W         = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_req_type,
  input  logic [KEY_PORT_W-1:0] in_key_row,
  input  logic [KEY_PORT_W-1:0] in_key_col,
  input  logic [VALUE_W-1:0]    in_value_in,
  // result channel
  output logic                  out_valid,
  output logic                  out_found,
  output logic [1:0]            out_status,
  output logic [POS_W-1:0]      out_position,
  output logic [VALUE_W-1:0]    out_value_out,
  output logic [POS_W-1:0]      out_entry_count
);

  localparam int KEY_W = 2 * KEY_HALF_BITS;

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  state_t     state_r, state_nxt;
  cell_ctrl_t ctrl;
  logic       accept;
  logic       commit;

  assign accept = start && !busy;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   state_nxt = start ? ST_CMP : ST_IDLE;
      ST_CMP:    state_nxt = ST_COMMIT;
      ST_COMMIT: state_nxt = start ? ST_CMP : ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    busy   = 1'b0;
    commit = 1'b0;
    unique case (state_r)
      ST_IDLE:   ;
      ST_CMP:    busy = 1'b1;
      ST_COMMIT: commit = 1'b1;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Request capture: hold key and value through compare and commit
  // --------------------------------------------------------------------------
  logic [KEY_EXT_W-1:0] row_ext, col_ext;
  logic                 req_type_r;
  logic [KEY_W-1:0]     req_key_r;
  logic [VALUE_W-1:0]   req_value_r;

  // only the low KEY_HALF_BITS of each part take part in the key
  assign row_ext = KEY_EXT_W'(in_key_row);
  assign col_ext = KEY_EXT_W'(in_key_col);

  always_ff @(posedge clk) begin
    if (accept) begin
      req_type_r  <= in_req_type;
      req_key_r   <= {row_ext[KEY_HALF_BITS-1:0], col_ext[KEY_HALF_BITS-1:0]};
      req_value_r <= in_value_in;
    end
  end

  // --------------------------------------------------------------------------
  // Cell chain
  // --------------------------------------------------------------------------
  logic [POS_W-1:0]   count_r, count_nxt;
  logic [KEY_W-1:0]   cell_key   [DEPTH];
  logic [VALUE_W-1:0] cell_value [DEPTH];
  cell_flags_t        cell_flags [DEPTH];
  logic [DEPTH-1:0]   less_vec;
  logic [DEPTH-1:0]   eq_vec;
  logic [DEPTH-1:0]   prev_less_vec;
  logic               do_insert;

  assign ctrl.cmp_en   = (state_r == ST_CMP);
  assign ctrl.shift_en = commit && do_insert;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic               occ;
    logic [KEY_W-1:0]   nb_key;
    logic [VALUE_W-1:0] nb_value;

    // a cell holds an entry while its index is below the fill count
    assign occ = (POS_W'(i) < count_r);
    assign less_vec[i] = cell_flags[i].less;
    assign eq_vec[i]   = cell_flags[i].eq;

    if (i == 0) begin : g_head
      assign prev_less_vec[i] = 1'b1;
      assign nb_key           = req_key_r;
      assign nb_value         = req_value_r;
    end else begin : g_body
      assign prev_less_vec[i] = cell_flags[i-1].less;
      assign nb_key           = cell_key[i-1];
      assign nb_value         = cell_value[i-1];
    end

    sct_cell #(
      .KEY_W (KEY_W)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occupied   (occ),
      .req_key    (req_key_r),
      .req_value  (req_value_r),
      .prev_less  (prev_less_vec[i]),
      .prev_key   (nb_key),
      .prev_value (nb_value),
      .key_r      (cell_key[i]),
      .value_r    (cell_value[i]),
      .flags_r    (cell_flags[i])
    );
  end

  // --------------------------------------------------------------------------
  // Commit: find the boundary of the sorted thermometer, encode position,
  // pick the matching value, decide the status
  // --------------------------------------------------------------------------
  logic [DEPTH-1:0]   boundary;
  logic [POS_W-1:0]   pos_c;
  logic [VALUE_W-1:0] hit_value;
  logic               hit;
  logic               full;
  status_t            status_c;

  assign boundary = prev_less_vec & ~less_vec;
  assign hit      = |eq_vec;
  assign full     = (count_r == POS_W'(DEPTH));

  always_comb begin
    pos_c     = '0;
    hit_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      pos_c     = pos_c | (boundary[i] ? POS_W'(i) : '0);
      hit_value = hit_value | (eq_vec[i] ? cell_value[i] : '0);
    end
    // every held key is smaller: the gap lies past the last cell
    if (less_vec[DEPTH-1]) begin
      pos_c = POS_W'(DEPTH);
    end
  end

  always_comb begin
    do_insert = 1'b0;
    status_c  = STATUS_OK;
    if (req_type_r == REQ_INSERT) begin
      if (hit) begin
        status_c = STATUS_DUP;
      end else if (full) begin
        status_c = STATUS_FULL;
      end else begin
        do_insert = 1'b1;
      end
    end
  end

  assign count_nxt = do_insert ? count_r + POS_W'(1) : count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= commit;
      if (commit) begin
        count_r <= count_nxt;
      end
    end
  end

  // result payload, loaded at the commit edge
  always_ff @(posedge clk) begin
    if (commit) begin
      out_found       <= hit;
      out_status      <= status_c;
      out_position    <= pos_c;
      out_value_out   <= hit_value;
      out_entry_count <= count_nxt;
    end
  end

endmodule

// File: rtl/sct_cell.sv
// ----------------------------------------------------------------------------
// sct_cell
// One slot of the sorted chain: holds a key and a value, compares the key
// against the request, and on insert takes the new entry or its lower
// neighbor's entry.
// ----------------------------------------------------------------------------
module sct_cell import sct_pkg::*; #(
  parameter int KEY_W = 2 * KEY_HALF_DEF
) (
  input  logic               clk,
  input  cell_ctrl_t         ctrl,
  input  logic               occupied,
  input  logic [KEY_W-1:0]   req_key,
  input  logic [VALUE_W-1:0] req_value,
  input  logic               prev_less,
  input  logic [KEY_W-1:0]   prev_key,
  input  logic [VALUE_W-1:0] prev_value,
  output logic [KEY_W-1:0]   key_r,
  output logic [VALUE_W-1:0] value_r,
  output cell_flags_t        flags_r
);

  cell_flags_t flags_nxt;

  always_comb begin
    flags_nxt.less = occupied && (key_r < req_key);
    flags_nxt.eq   = occupied && (key_r == req_key);
  end

  always_ff @(posedge clk) begin
    if (ctrl.cmp_en) begin
      flags_r <= flags_nxt;
    end
    // entries at or above the gap move up; the gap cell takes the request
    if (ctrl.shift_en && !flags_r.less) begin
      if (prev_less) begin
        key_r   <= req_key;
        value_r <= req_value;
      end else begin
        key_r   <= prev_key;
        value_r <= prev_value;
      end
    end
  end

endmodule
